### rtl/pls_pkg.sv
// Shared types and codes for the positional list store.
package pls_pkg;

  localparam int unsigned OpW  = 2;
  localparam int unsigned ValW = 32;
  localparam int unsigned PosW = 6;
  localparam int unsigned StW  = 2;

  typedef enum logic [OpW-1:0] {
    OpInsertFront = 2'd0,
    OpDeleteFirst = 2'd1,
    OpDeleteEnd   = 2'd2,
    OpDeleteAt    = 2'd3
  } pls_op_e;

  typedef enum logic [StW-1:0] {
    StOk    = 2'd0,
    StEmpty = 2'd1,
    StOob   = 2'd2,
    StFull  = 2'd3
  } pls_status_e;

  typedef struct packed {
    logic take_left;
    logic take_right;
  } pls_shift_t;

endpackage

### rtl/positional_list_store.sv
// Top level of the positional list store: a bounded ordered list in a chain of cells.
// Usage:
// Each input item is one operation on the list: insert at front, delete the
// first entry, delete the last entry, or delete the entry at a given position.
// Every accepted item yields exactly one result item carrying a status, the
// entry count after the operation and the value now at the head of the list.
// The entries live in a row of DEPTH cells; each shifting cell loads from its left or
// right neighbor at the same clock edge, so an operation updates the row at once.
// A result appears on the output in the cycle after its item is accepted, and a
// new item may be accepted every cycle the output is not stalled: one item per cycle.
// The result sits in an output register; while the receiver stalls it, the
// result holds and in_stall_o is raised, so no further item is accepted.
// Reset empties the list and clears the output valid; the cell contents are
// not cleared, since only entries below the count are ever read.
// An insert into a full list is dropped with status full, a delete on an
// empty list reports empty, and a delete at a position not below the count
// reports out of bound; in those cases the list is unchanged.
module positional_list_store #(
  parameter int unsigned DEPTH = 64,
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [pls_pkg::OpW-1:0]           opcode_i,
  input  logic signed [pls_pkg::ValW-1:0]   value_i,
  input  logic [pls_pkg::PosW-1:0]          position_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [pls_pkg::StW-1:0]           status_o,
  output logic [CntW-1:0]                   entry_count_o,
  output logic signed [pls_pkg::ValW-1:0]   head_value_o
);
  import pls_pkg::*;

  logic                out_valid_q, out_valid_d;
  pls_status_e         status_q, status_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                accept;
  pls_op_e             op;
  logic                do_insert;
  logic                do_remove;
  logic [31:0]         shift_from;
  logic signed [ValW-1:0] cell_data [DEPTH];

  assign op         = pls_op_e'(opcode_i);
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    status_d  = StOk;
    count_d   = count_q;
    do_insert = 1'b0;
    do_remove = 1'b0;
    if (op == OpInsertFront) begin
      if (32'(count_q) >= DEPTH) begin
        status_d = StFull;
      end else begin
        do_insert = 1'b1;
        count_d   = count_q + CntW'(1);
      end
    end else if (count_q == '0) begin
      status_d = StEmpty;
    end else if (op == OpDeleteAt && 32'(position_i) >= 32'(count_q)) begin
      status_d = StOob;
    end else begin
      do_remove = (op != OpDeleteEnd);
      count_d   = count_q - CntW'(1);
    end
  end

  assign shift_from  = (op == OpDeleteFirst) ? 32'd0 : 32'(position_i);
  assign out_valid_d = accept ? 1'b1 : (out_valid_q && out_stall_i);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    pls_shift_t             ctrl;
    logic signed [ValW-1:0] left_data;
    logic signed [ValW-1:0] right_data;

    assign ctrl.take_left  = accept && do_insert;
    assign ctrl.take_right = accept && do_remove && (32'(i) >= shift_from);

    if (i == 0) begin : g_first
      assign left_data = value_i;
    end else begin : g_mid_left
      assign left_data = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_data = cell_data[i];
    end else begin : g_mid_right
      assign right_data = cell_data[i+1];
    end

    pls_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .left_i  (left_data),
      .right_i (right_data),
      .data_o  (cell_data[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      count_q     <= '0;
      status_q    <= StOk;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        count_q  <= count_d;
        status_q <= status_d;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign entry_count_o = count_q;
  assign head_value_o  = (count_q == '0) ? '0 : cell_data[0];

endmodule

### rtl/pls_cell.sv
// One list cell: holds one entry and loads from either neighbor.
module pls_cell (
  input  logic                                clk_i,
  input  pls_pkg::pls_shift_t                 ctrl_i,
  input  logic signed [pls_pkg::ValW-1:0]     left_i,
  input  logic signed [pls_pkg::ValW-1:0]     right_i,
  output logic signed [pls_pkg::ValW-1:0]     data_o
);
  import pls_pkg::*;

  logic signed [ValW-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.take_left) begin
      data_d = left_i;
    end else if (ctrl_i.take_right) begin
      data_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule
